// ----- rtl/key_debounce_event_fifo_core_defines.svh -----
// assertion macros shared by the key debounce event fifo rtl
`ifndef KEY_DEBOUNCE_EVENT_FIFO_CORE_DEFINES_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_CORE_DEFINES_SVH

// same-cycle implication
`define KDEF_ASSERT_IMP(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kdef assertion failed");

// next-cycle implication
`define KDEF_ASSERT_NEXT(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kdef assertion failed");

`endif

// ----- rtl/kdef_pkg.sv -----
// types, constants and helpers for the key debounce event fifo
`timescale 1ns / 1ps

package kdef_pkg;

	localparam int unsigned NUM_KEYS_DEF   = 3;
	localparam int unsigned RING_DEPTH_DEF = 16;

	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned RAW_W     = 3;
	localparam int unsigned CODE_W    = 4;
	localparam int unsigned HELD_W    = 3;
	localparam int unsigned FILTER_W  = 7;
	localparam int unsigned FCOUNT_W  = 8;
	localparam int unsigned LONG_W    = 16;
	localparam int unsigned REPEAT_W  = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 8;

	localparam logic [FILTER_W-1:0] FILTER_TICKS_RST = 7'd5;
	localparam logic [FCOUNT_W-1:0] FILTER_COUNT_RST = FCOUNT_W'(FILTER_TICKS_RST / 2);
	localparam logic [LONG_W-1:0]   LONG_TICKS_RST   = 16'd100;
	localparam logic [REPEAT_W-1:0] REPEAT_TICKS_RST = 8'd0;

	// register indexes on the config channel
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FILTER      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_REPEAT_BASE = 3'd4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SCAN       = 2'd0,
		ACT_POP_MAIN   = 2'd1,
		ACT_POP_SECOND = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		EV_DOWN = 2'd1,
		EV_UP   = 2'd2,
		EV_LONG = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic              vld;
		logic [CODE_W-1:0] code;
	} push_t;

	function automatic logic [CODE_W-1:0] ev_code(input int unsigned key, input ev_kind_t kind);
		return CODE_W'(3 * key + int'(kind));
	endfunction

endpackage

// ----- rtl/kdef_key.sv -----
// debounce, long-press and auto-repeat logic of one key
`timescale 1ns / 1ps

module kdef_key
	import kdef_pkg::*;
#(
	parameter int unsigned KEY_ID = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                pressed,
	input  logic [FILTER_W-1:0] filter_ticks,
	input  logic [LONG_W-1:0]   long_ticks,
	input  logic [REPEAT_W-1:0] repeat_ticks,
	output push_t [1:0]         push,
	output logic                held_d
);

	logic [FCOUNT_W-1:0] fc_q, fc_d;
	logic                down_q, down_d;
	logic [LONG_W-1:0]   lc_q, lc_d, lc_inc;
	logic [REPEAT_W-1:0] rc_q, rc_d, rc_inc;
	logic [FCOUNT_W-1:0] ft_ext, top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= FILTER_COUNT_RST;
			down_q <= 1'b0;
			lc_q   <= '0;
			rc_q   <= '0;
		end else begin
			fc_q   <= fc_d;
			down_q <= down_d;
			lc_q   <= lc_d;
			rc_q   <= rc_d;
		end
	end

	always_comb begin
		ft_ext = {1'b0, filter_ticks};
		top    = {filter_ticks, 1'b0};
		lc_inc = lc_q + 16'd1;
		rc_inc = rc_q + 8'd1;
		fc_d   = fc_q;
		down_d = down_q;
		lc_d   = lc_q;
		rc_d   = rc_q;
		push   = '0;
		if (en) begin
			if (pressed) begin
				if (fc_q < ft_ext) begin
					fc_d = ft_ext;
				end else if (fc_q < top) begin
					fc_d = fc_q + 8'd1;
				end else begin
					if (!down_q) begin
						down_d       = 1'b1;
						push[0].vld  = 1'b1;
						push[0].code = ev_code(KEY_ID, EV_DOWN);
					end
					if (long_ticks != '0) begin
						if (lc_q < long_ticks) begin
							lc_d = lc_inc;
							if (lc_inc == long_ticks) begin
								push[1].vld  = 1'b1;
								push[1].code = ev_code(KEY_ID, EV_LONG);
							end
						end
					end else if (repeat_ticks != '0) begin
						if (rc_inc >= repeat_ticks) begin
							rc_d         = '0;
							push[1].vld  = 1'b1;
							push[1].code = ev_code(KEY_ID, EV_DOWN);
						end else begin
							rc_d = rc_inc;
						end
					end
				end
			end else begin
				if (fc_q > ft_ext) begin
					fc_d = ft_ext;
				end else if (fc_q != '0) begin
					fc_d = fc_q - 8'd1;
				end else if (down_q) begin
					down_d       = 1'b0;
					push[0].vld  = 1'b1;
					push[0].code = ev_code(KEY_ID, EV_UP);
				end
				lc_d = '0;
				rc_d = '0;
			end
		end
		held_d = down_d;
	end

endmodule

// ----- rtl/kdef_ring.sv -----
// event ring with multi-push write side and two independent readers
`timescale 1ns / 1ps
`include "key_debounce_event_fifo_core_defines.svh"

module kdef_ring
	import kdef_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
	parameter int unsigned NUM_PUSH   = 2 * NUM_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  push_t [NUM_PUSH-1:0] push,
	input  logic                pop_main,
	input  logic                pop_second,
	output logic [CODE_W-1:0]   pop_code
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

	logic [CODE_W-1:0] ring_q [RING_DEPTH];
	logic [PTR_W-1:0]  wp_q, rp_main_q, rp_second_q;
	logic [PTR_W-1:0]  wp_d, rp_sel, cur;
	logic [PTR_W-1:0]  addr [NUM_PUSH];
	logic              empty;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	// pushes land at consecutive slots in key order
	always_comb begin
		cur = wp_q;
		for (int j = 0; j < NUM_PUSH; j++) begin
			addr[j] = cur;
			if (push[j].vld)
				cur = ptr_inc(cur);
		end
		wp_d = cur;
	end

	always_comb begin
		rp_sel   = pop_second ? rp_second_q : rp_main_q;
		empty    = (rp_sel == wp_q);
		pop_code = empty ? '0 : ring_q[rp_sel];
	end

	// later pushes win where an overrun wraps onto an earlier one
	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_PUSH; j++) begin
			if (push[j].vld)
				ring_q[addr[j]] <= push[j].code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_main_q   <= '0;
			rp_second_q <= '0;
		end else begin
			wp_q <= wp_d;
			if (pop_main && !empty)
				rp_main_q <= ptr_inc(rp_main_q);
			if (pop_second && !empty)
				rp_second_q <= ptr_inc(rp_second_q);
		end
	end

	`KDEF_ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1, (wp_q <= LAST) && (rp_main_q <= LAST) && (rp_second_q <= LAST))

endmodule

// ----- rtl/key_debounce_event_fifo_core.sv -----
// top level of the key debounce event fifo
`timescale 1ns / 1ps
`include "key_debounce_event_fifo_core_defines.svh"

// usage
//  s_* stream: one transaction per action; scan ticks carry the raw key levels,
//   pops take the next code from the main or second reader
//  m_* stream: exactly one result per input transaction, in order: popped code
//   (0 when empty or on a scan tick) and the debounced held keys after the action
//  cfg_*: register writes by index, always ready; write only while idle
//  a transaction passes the input register, then the result register; one
//   transaction per cycle sustained while m_tready is high, all key updates and
//   up to two pushes per key done in the single stage between
//  a stalled m_tready holds the result; the input register still takes one
//   more transaction, after which s_tready drops until the result goes
//  reset clears held state, ring pointers and long/repeat counters, loads register
//   defaults; ring contents need no clearing as readers only see written slots

module key_debounce_event_fifo_core
	import kdef_pkg::*;
#(
	parameter int unsigned NUM_KEYS   = NUM_KEYS_DEF,
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // action[1:0], raw_pressed[4:2], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // key_code[3:0], held_keys[6:4], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned NUM_PUSH = 2 * NUM_KEYS;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [RAW_W-1:0]    raw_s1;
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                fire_s1, scan_en, pop_main, pop_second;

	logic [FILTER_W-1:0] filter_ticks_q;
	logic [LONG_W-1:0]   long_ticks_q   [NUM_KEYS];
	logic [REPEAT_W-1:0] repeat_ticks_q [NUM_KEYS];

	push_t [NUM_PUSH-1:0] push;
	logic [NUM_KEYS-1:0]  held_bits;
	logic [HELD_W-1:0]    held_keys;
	logic [CODE_W-1:0]    pop_code;
	logic [CODE_W-1:0]    code_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_ticks_q <= FILTER_TICKS_RST;
			for (int k = 0; k < NUM_KEYS; k++) begin
				long_ticks_q[k]   <= LONG_TICKS_RST;
				repeat_ticks_q[k] <= REPEAT_TICKS_RST;
			end
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDX_FILTER)
				filter_ticks_q <= cfg_data[FILTER_W-1:0];
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (cfg_index == CFG_IDX_LONG_BASE + CFG_IDX_W'(k))
					long_ticks_q[k] <= cfg_data[LONG_W-1:0];
				if (cfg_index == CFG_IDX_REPEAT_BASE + CFG_IDX_W'(k))
					repeat_ticks_q[k] <= cfg_data[REPEAT_W-1:0];
			end
		end
	end

	// input register and result register
	assign fire_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || fire_s1;
	assign scan_en    = fire_s1 && (action_s1 == ACT_SCAN);
	assign pop_main   = fire_s1 && (action_s1 == ACT_POP_MAIN);
	assign pop_second = fire_s1 && (action_s1 == ACT_POP_SECOND);

	// only pops report a code
	assign code_out = (pop_main || pop_second) ? pop_code : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (fire_s1)
				valid_s1 <= 1'b0;
			if (fire_s1)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tdata[ACTION_W-1:0];
			raw_s1    <= s_tdata[ACTION_W +: RAW_W];
		end
		if (fire_s1)
			out_data_q <= M_TDATA_W'({held_keys, code_out});
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		kdef_key #(
			.KEY_ID (k)
		) u_key (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (scan_en),
			.pressed      (raw_s1[k]),
			.filter_ticks (filter_ticks_q),
			.long_ticks   (long_ticks_q[k]),
			.repeat_ticks (repeat_ticks_q[k]),
			.push         (push[2*k +: 2]),
			.held_d       (held_bits[k])
		);
	end

	assign held_keys = HELD_W'(held_bits);

	kdef_ring #(
		.RING_DEPTH (RING_DEPTH),
		.NUM_PUSH   (NUM_PUSH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop_main   (pop_main),
		.pop_second (pop_second),
		.pop_code   (pop_code)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`KDEF_ASSERT_NEXT(a_scan_no_code, clk, arst_n, scan_en, m_tdata[CODE_W-1:0] == '0)
	`KDEF_ASSERT_IMP(a_stall_only_full, clk, arst_n, !s_tready, valid_s1 && out_valid_q && !m_tready)
	`KDEF_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire_s1, m_tvalid)

endmodule
